/* rtl/vtpd_pkg.sv */
// Shared types and constants for the vertex transform and perspective divide block.
// Depends on nothing; vtpd_div_pipe and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package vtpd_pkg;

    // Command codes carried on the input channel.
    localparam logic CMD_WRITE_COEFF = 1'b0;
    localparam logic CMD_TRANSFORM   = 1'b1;

    // Coordinate lanes that are divided by w (x, y, z).
    localparam int LANES = 3;
    // Matrix columns, including the w column.
    localparam int COLS = 4;
    // Vertex rows that are multiplied; the fourth row is the translation.
    localparam int ROWS = 3;
    localparam int COEFFS = 16;

    // Signed accumulator width of the sums of products.
    localparam int ACC_W = 67;
    localparam int Q_W = 32;

    // Divider organization: quotient bits resolved per pipeline stage.
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = Q_W / DIV_BITS_PER_STAGE;

    localparam logic [Q_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // Per-vertex side information that travels with the divider lanes.
    typedef struct packed {
        logic                      wz;
        logic [LANES-1:0]          neg;
        logic [LANES-1:0]          ovf;
        logic                      pass_sat;
        logic [LANES-1:0][Q_W-1:0] pass;
    } vtpd_meta_t;

endpackage
`default_nettype wire

/* rtl/vtpd_cmd_if.sv */
// Input channel of the vertex transform block: coefficient writes and vertices.
// Stands alone; the payload widths follow the block's field list.
`timescale 1ns / 1ps
`default_nettype none
interface vtpd_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [3:0]  coeff_index;
    logic [31:0] coeff_value;
    logic [31:0] in_x;
    logic [31:0] in_y;
    logic [31:0] in_z;

    modport source (output valid, command, coeff_index, coeff_value, in_x, in_y, in_z,
                    input ready);
    modport sink (input valid, command, coeff_index, coeff_value, in_x, in_y, in_z,
                  output ready);
endinterface
`default_nettype wire

/* rtl/vtpd_result_if.sv */
// Output channel of the vertex transform block: transformed vertices and flags.
// Stands alone; the payload widths follow the block's field list.
`timescale 1ns / 1ps
`default_nettype none
interface vtpd_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic        w_zero;
    logic        saturated;

    modport source (output valid, out_x, out_y, out_z, w_zero, saturated, input ready);
    modport sink (input valid, out_x, out_y, out_z, w_zero, saturated, output ready);
endinterface
`default_nettype wire

/* rtl/vtpd_div_pipe.sv */
// Pipelined restoring divider for the three coordinate lanes, sharing one divisor.
// Depends on vtpd_pkg for widths, stage count and the side information struct.
`timescale 1ns / 1ps
`default_nettype none
module vtpd_div_pipe (
    input  wire logic                                                 clk,
    input  wire logic                                                 rst_n,
    input  wire logic                                                 en,
    input  wire logic                                                 in_valid,
    input  wire vtpd_pkg::vtpd_meta_t                                 in_meta,
    input  wire logic [vtpd_pkg::LANES-1:0][vtpd_pkg::ACC_W-1:0]     in_rem,
    input  wire logic [vtpd_pkg::LANES-1:0][vtpd_pkg::Q_W-1:0]       in_lq,
    input  wire logic [vtpd_pkg::ACC_W-1:0]                           in_den,
    output logic                                                      out_valid,
    output vtpd_pkg::vtpd_meta_t                                      out_meta,
    output logic [vtpd_pkg::LANES-1:0][vtpd_pkg::Q_W-1:0]            out_quo
);
    localparam int NS  = vtpd_pkg::DIV_STAGES;
    localparam int BPS = vtpd_pkg::DIV_BITS_PER_STAGE;
    localparam int AW  = vtpd_pkg::ACC_W;
    localparam int QW  = vtpd_pkg::Q_W;
    localparam int NL  = vtpd_pkg::LANES;

    // Stage boundaries; index 0 is the divider input.
    logic                           st_valid [NS+1];
    vtpd_pkg::vtpd_meta_t           st_meta  [NS+1];
    logic [NL-1:0][AW-1:0]          st_rem   [NS+1];
    logic [NL-1:0][QW-1:0]          st_lq    [NS+1];
    logic [AW-1:0]                  st_den   [NS+1];

    assign st_valid[0] = in_valid;
    assign st_meta[0]  = in_meta;
    assign st_rem[0]   = in_rem;
    assign st_lq[0]    = in_lq;
    assign st_den[0]   = in_den;

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic                  valid_reg;
        vtpd_pkg::vtpd_meta_t  meta_reg;
        logic [NL-1:0][AW-1:0] rem_reg;
        logic [NL-1:0][AW-1:0] rem_next;
        logic [NL-1:0][QW-1:0] lq_reg;
        logic [NL-1:0][QW-1:0] lq_next;
        logic [AW-1:0]         den_reg;

        // The low word shifts numerator bits out at the top and quotient bits in
        // at the bottom, so after the last stage it holds the quotient.
        always_comb
        begin
            logic [AW:0]   rem;
            logic [QW-1:0] lq;
            rem_next = st_rem[g];
            lq_next  = st_lq[g];
            for (int l = 0; l < NL; l++)
            begin
                rem = {1'b0, st_rem[g][l]};
                lq  = st_lq[g][l];
                for (int b = 0; b < BPS; b++)
                begin
                    rem = {rem[AW-1:0], lq[QW-1]};
                    lq  = {lq[QW-2:0], 1'b0};
                    if (rem >= {1'b0, st_den[g]})
                    begin
                        rem   = rem - {1'b0, st_den[g]};
                        lq[0] = 1'b1;
                    end
                end
                rem_next[l] = rem[AW-1:0];
                lq_next[l]  = lq;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= st_valid[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                meta_reg <= st_meta[g];
                rem_reg  <= rem_next;
                lq_reg   <= lq_next;
                den_reg  <= st_den[g];
            end
        end

        assign st_valid[g+1] = valid_reg;
        assign st_meta[g+1]  = meta_reg;
        assign st_rem[g+1]   = rem_reg;
        assign st_lq[g+1]    = lq_reg;
        assign st_den[g+1]   = den_reg;
    end

    assign out_valid = st_valid[NS];
    assign out_meta  = st_meta[NS];
    assign out_quo   = st_lq[NS];

endmodule
`default_nettype wire

/* rtl/vertex_transform_perspective_divide.sv */
// Top level of the 4x4 matrix vertex transform with perspective divide.
// Depends on vtpd_pkg, the vtpd_cmd_if and vtpd_result_if channels and vtpd_div_pipe.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Interface        Role    Transaction
//  cmd       vtpd_cmd_if      sink    coefficient write or vertex to transform
//  result    vtpd_result_if   source  transformed vertex with w_zero and saturated
//
// One transaction is accepted per clock while result is not stalled; a vertex passes through
// multiply, sum, magnitude, divide setup, sixteen divider stages and the output register.
// The divider resolves two quotient bits per stage.
// Reset loads the identity matrix and empties the pipeline.
// A stall on result freezes every stage at once and drops cmd.ready in the same cycle.
// A coefficient write lands in the matrix at acceptance and is seen by the next vertex.
module vertex_transform_perspective_divide #(
    parameter int FRAC_BITS = 16
) (
    input wire logic      clk,
    input wire logic      rst_n,
    vtpd_cmd_if.sink      cmd,
    vtpd_result_if.source result
);
    localparam int AW    = vtpd_pkg::ACC_W;
    localparam int QW    = vtpd_pkg::Q_W;
    localparam int NL    = vtpd_pkg::LANES;
    localparam int NC    = vtpd_pkg::COLS;
    localparam int NR    = vtpd_pkg::ROWS;
    localparam int NUM_W = AW + FRAC_BITS;
    localparam int CMP_W = AW + QW + FRAC_BITS;

    // The whole pipeline moves together whenever the output register can move.
    logic en;
    logic out_valid_reg;
    assign en        = !out_valid_reg || result.ready;
    assign cmd.ready = en;

    logic accept;
    assign accept = cmd.valid && en;

    // Coefficient store, reset to the identity matrix.
    logic [vtpd_pkg::COEFFS-1:0][QW-1:0] coeff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vtpd_pkg::COEFFS; i++)
            begin
                coeff_reg[i] <= (i % 5 == 0) ? (QW'(1) << FRAC_BITS) : '0;
            end
        end
        else if (accept && cmd.command == vtpd_pkg::CMD_WRITE_COEFF)
        begin
            coeff_reg[cmd.coeff_index] <= cmd.coeff_value;
        end
    end

    // Stage 1: the twelve products and the translation row.
    logic                          s1_valid_reg;
    logic [NC-1:0][NR-1:0][63:0]   prod_reg;
    logic [NC-1:0][NR-1:0][63:0]   prod_next;
    logic [NC-1:0][QW-1:0]         trans_reg;
    logic [NR-1:0][QW-1:0]         vert;

    assign vert = {cmd.in_z, cmd.in_y, cmd.in_x};

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            for (int r = 0; r < NR; r++)
            begin
                prod_next[c][r] = 64'($signed(vert[r])) * 64'($signed(coeff_reg[r*NC+c]));
            end
        end
    end

    // Stage 2: the four sums of products.
    logic                    s2_valid_reg;
    logic [NC-1:0][AW-1:0]   sum_reg;
    logic [NC-1:0][AW-1:0]   sum_next;

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            sum_next[c] = AW'($signed(prod_reg[c][0])) + AW'($signed(prod_reg[c][1]))
                        + AW'($signed(prod_reg[c][2]))
                        + (AW'($signed(trans_reg[c])) << FRAC_BITS);
        end
    end

    // Stage 3: signs and magnitudes; column 3 is w.
    logic                    s3_valid_reg;
    logic [NC-1:0]           neg_reg;
    logic [NC-1:0]           neg_next;
    logic [NC-1:0][AW-1:0]   mag_reg;
    logic [NC-1:0][AW-1:0]   mag_next;

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            neg_next[c] = sum_reg[c][AW-1];
            mag_next[c] = neg_next[c] ? AW'(0) - sum_reg[c] : sum_reg[c];
        end
    end

    // Stage 4: divider setup. The scaled numerator is checked against w shifted by
    // the quotient width, so the divider only has to find a 32-bit quotient. The
    // zero-w result is finished here and rides along as side information.
    logic                         s4_valid_reg;
    vtpd_pkg::vtpd_meta_t         meta_reg;
    vtpd_pkg::vtpd_meta_t         meta_next;
    logic [NL-1:0][AW-1:0]        rem_reg;
    logic [NL-1:0][AW-1:0]        rem_next;
    logic [NL-1:0][QW-1:0]        lq_reg;
    logic [NL-1:0][QW-1:0]        lq_next;
    logic [AW-1:0]                den_reg;

    always_comb
    begin
        logic [NUM_W-1:0] num;
        logic [AW-1:0]    pv;
        logic [QW-1:0]    lim;
        meta_next          = '0;
        meta_next.wz       = (mag_reg[NC-1] == '0);
        rem_next           = '0;
        lq_next            = '0;
        for (int l = 0; l < NL; l++)
        begin
            num              = NUM_W'(mag_reg[l]) << FRAC_BITS;
            meta_next.ovf[l] = CMP_W'(num) >= (CMP_W'(mag_reg[NC-1]) << QW);
            meta_next.neg[l] = meta_next.wz ? neg_reg[l] : (neg_reg[l] ^ neg_reg[NC-1]);
            rem_next[l]      = AW'(num >> QW);
            lq_next[l]       = num[QW-1:0];
            pv               = mag_reg[l] >> FRAC_BITS;
            lim              = neg_reg[l] ? vtpd_pkg::NEG_LIMIT : vtpd_pkg::POS_LIMIT;
            if (pv > AW'(lim))
            begin
                meta_next.pass_sat = 1'b1;
                meta_next.pass[l]  = lim;
            end
            else
            begin
                meta_next.pass[l] = neg_reg[l] ? QW'(0) - pv[QW-1:0] : pv[QW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= cmd.valid && cmd.command == vtpd_pkg::CMD_TRANSFORM;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            for (int c = 0; c < NC; c++)
            begin
                trans_reg[c] <= coeff_reg[NR*NC+c];
            end
            sum_reg   <= sum_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            meta_reg  <= meta_next;
            rem_reg   <= rem_next;
            lq_reg    <= lq_next;
            den_reg   <= mag_reg[NC-1];
        end
    end

    // Divider stages.
    logic                       div_valid;
    vtpd_pkg::vtpd_meta_t       div_meta;
    logic [NL-1:0][QW-1:0]      div_quo;

    vtpd_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .in_meta   (meta_reg),
        .in_rem    (rem_reg),
        .in_lq     (lq_reg),
        .in_den    (den_reg),
        .out_valid (div_valid),
        .out_meta  (div_meta),
        .out_quo   (div_quo)
    );

    // Output stage: sign, clamp and flag selection.
    logic [NL-1:0][QW-1:0] res_reg;
    logic [NL-1:0][QW-1:0] res_next;
    logic                  wz_reg;
    logic                  sat_reg;
    logic                  sat_next;

    always_comb
    begin
        logic [QW-1:0] lim;
        lim      = vtpd_pkg::POS_LIMIT;
        sat_next = div_meta.wz ? div_meta.pass_sat : 1'b0;
        res_next = div_meta.pass;
        if (!div_meta.wz)
        begin
            for (int l = 0; l < NL; l++)
            begin
                lim = div_meta.neg[l] ? vtpd_pkg::NEG_LIMIT : vtpd_pkg::POS_LIMIT;
                if (div_meta.ovf[l] || div_quo[l] > lim)
                begin
                    sat_next    = 1'b1;
                    res_next[l] = lim;
                end
                else
                begin
                    res_next[l] = div_meta.neg[l] ? QW'(0) - div_quo[l] : div_quo[l];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            wz_reg  <= div_meta.wz;
            sat_reg <= sat_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_x     = res_reg[0];
    assign result.out_y     = res_reg[1];
    assign result.out_z     = res_reg[2];
    assign result.w_zero    = wz_reg;
    assign result.saturated = sat_reg;

    // A coefficient write must never start a vertex down the pipeline.
    a_write_no_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == vtpd_pkg::CMD_WRITE_COEFF |=> !s1_valid_reg)
        else $error("coefficient write entered the vertex pipeline");

    // An accepted vertex occupies the first stage on the next cycle.
    a_vertex_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == vtpd_pkg::CMD_TRANSFORM |=> s1_valid_reg)
        else $error("accepted vertex was lost at pipeline entry");

    // A write lands in the addressed coefficient.
    a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.command == vtpd_pkg::CMD_WRITE_COEFF
        |=> coeff_reg[$past(cmd.coeff_index)] == $past(cmd.coeff_value))
        else $error("coefficient write did not reach the matrix");

    // While the output stalls, the valid flags of stage 1, stage 4 and the divider output hold.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s4_valid_reg) && $stable(div_valid) && $stable(s1_valid_reg))
        else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
